### rtl/core/wts_pkg.sv
// Shared types and constants for the warning transfer session engine.
// No dependencies; imported by wts_event and warning_transfer_session_fsm.
package wts_pkg;

    localparam logic [2:0] CMD_CONNECT    = 3'd0;
    localparam logic [2:0] CMD_DISCONNECT = 3'd1;
    localparam logic [2:0] CMD_AUTH       = 3'd2;
    localparam logic [2:0] CMD_SET_LEN    = 3'd3;
    localparam logic [2:0] CMD_CHUNK      = 3'd4;
    localparam logic [2:0] CMD_CLIENT_ACK = 3'd5;
    localparam logic [2:0] CMD_STATUS     = 3'd6;

    localparam logic [1:0] PHASE_CODE_INACTIVE  = 2'd0;
    localparam logic [1:0] PHASE_CODE_RECEIVING = 2'd1;
    localparam logic [1:0] PHASE_CODE_COMPLETE  = 2'd2;
    localparam logic [1:0] PHASE_CODE_ACKED     = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] DISP_WAIT_KNOWN    = 3'd0;
    localparam logic [2:0] DISP_WAIT_AUTH     = 3'd1;
    localparam logic [2:0] DISP_ALL_VALID     = 3'd2;
    localparam logic [2:0] DISP_SHORT_INVALID = 3'd3;
    localparam logic [2:0] DISP_ACTIVE_WARN   = 3'd4;
    localparam logic [2:0] DISP_ACKED         = 3'd5;

    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_UNAUTH      = 3'd1;
    localparam logic [2:0] ERR_BAD_STATUS  = 3'd2;
    localparam logic [2:0] ERR_FUTURE_TIME = 3'd3;
    localparam logic [2:0] ERR_WRONG_SEQ   = 3'd4;
    localparam logic [2:0] ERR_IGNORED     = 3'd5;
    localparam logic [2:0] ERR_UNEXP_ACK   = 3'd6;
    localparam logic [2:0] ERR_WRONG_ID    = 3'd7;

    localparam logic [3:0] NIB_MAX        = 4'd5;
    localparam logic [3:0] NIB_LONG_LOW   = 4'd3;
    localparam logic [3:0] NIB_SHORT_HIGH = 4'd2;

    typedef enum logic [3:0] {
        PH_INACTIVE  = 4'b0001,
        PH_RECEIVING = 4'b0010,
        PH_COMPLETE  = 4'b0100,
        PH_ACKED     = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] device_id;
        logic [15:0] message_length;
        logic [15:0] chunk_seq;
        logic [7:0]  chunk_char;
        logic        client_ack;
        logic [15:0] status_word;
        logic [31:0] status_time;
        logic [31:0] current_time;
    } item_t;

    typedef struct packed {
        logic        authenticated;
        phase_t      phase;
        logic [15:0] next_seq;
        logic [15:0] total_chunks;
        logic [15:0] status_hold;
        logic [2:0]  screen_mode;
    } sess_t;

    typedef struct packed {
        logic [1:0]  warning_phase;
        logic [15:0] expected_seq;
        logic        seq_request;
        logic [1:0]  char_kind;
        logic [7:0]  char_value;
        logic [2:0]  display_state;
        logic        display_changed;
        logic        drop_client;
        logic        ack_write;
        logic        ack_write_value;
        logic [2:0]  error_code;
        logic [15:0] last_status;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_INACTIVE:  code = PHASE_CODE_INACTIVE;
            PH_RECEIVING: code = PHASE_CODE_RECEIVING;
            PH_COMPLETE:  code = PHASE_CODE_COMPLETE;
            PH_ACKED:     code = PHASE_CODE_ACKED;
            default:      code = PHASE_CODE_INACTIVE;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/wts_event.sv
// Combinational event step: session state and one event in, next state and result out.
// Depends on wts_pkg.
module wts_event import wts_pkg::*; (
    input  item_t       item,
    input  sess_t       cur,
    input  logic [31:0] stored_id,
    output sess_t       nxt,
    output result_t     res
);

    logic        bad, shortinv, longinv, allfive;
    logic [3:0]  nib;
    logic [15:0] seq_inc;
    logic [1:0]  kind;
    logic [7:0]  cval;
    logic        seq_req, changed, drop, aw, awv;
    logic [2:0]  err;

    always_comb begin
        bad      = 1'b0;
        shortinv = 1'b0;
        longinv  = 1'b0;
        allfive  = 1'b1;
        nib      = '0;
        for (int i = 0; i < 4; i++) begin
            nib = item.status_word[4*i +: 4];
            if (nib > NIB_MAX) bad = 1'b1;
            if (nib != 4'd0 && nib <= NIB_SHORT_HIGH) shortinv = 1'b1;
            if (nib >= NIB_LONG_LOW && nib < NIB_MAX) longinv = 1'b1;
            if (nib != NIB_MAX) allfive = 1'b0;
        end
    end

    assign seq_inc = cur.next_seq + 16'd1;

    always_comb begin
        nxt     = cur;
        kind    = KIND_NONE;
        cval    = '0;
        seq_req = 1'b0;
        changed = 1'b0;
        drop    = 1'b0;
        aw      = 1'b0;
        awv     = 1'b0;
        err     = ERR_OK;
        if (item.command >= CMD_SET_LEN && item.command <= CMD_STATUS &&
            !cur.authenticated) begin
            drop            = 1'b1;
            nxt.screen_mode = DISP_WAIT_KNOWN;
            changed         = 1'b1;
            err             = ERR_UNAUTH;
        end else begin
            case (item.command)
                CMD_CONNECT: begin
                    nxt.screen_mode = DISP_WAIT_AUTH;
                    changed         = 1'b1;
                end
                CMD_DISCONNECT: begin
                    nxt.authenticated = 1'b0;
                    nxt.status_hold   = '0;
                    nxt.phase         = PH_INACTIVE;
                    aw                = 1'b1;
                    nxt.screen_mode   = DISP_WAIT_KNOWN;
                    changed           = 1'b1;
                end
                CMD_AUTH: begin
                    if (item.device_id != stored_id) begin
                        drop = 1'b1;
                        err  = ERR_WRONG_ID;
                    end else begin
                        nxt.authenticated = 1'b1;
                        nxt.screen_mode   = DISP_ALL_VALID;
                        changed           = 1'b1;
                    end
                end
                CMD_SET_LEN: begin
                    nxt.total_chunks = item.message_length;
                    nxt.phase        = PH_RECEIVING;
                    nxt.next_seq     = '0;
                    nxt.screen_mode  = DISP_ACTIVE_WARN;
                    changed          = 1'b1;
                end
                CMD_CHUNK: begin
                    if (cur.phase != PH_RECEIVING) begin
                        err = ERR_IGNORED;
                    end else begin
                        seq_req = 1'b1;
                        if (item.chunk_seq == cur.next_seq) begin
                            if (item.chunk_char == 8'd0) begin
                                kind = KIND_END;
                            end else begin
                                kind = KIND_CHAR;
                                cval = item.chunk_char;
                            end
                            nxt.next_seq = seq_inc;
                            if (seq_inc >= cur.total_chunks) nxt.phase = PH_COMPLETE;
                        end else begin
                            err = ERR_WRONG_SEQ;
                        end
                    end
                end
                CMD_CLIENT_ACK: begin
                    if (item.client_ack && cur.phase == PH_COMPLETE) begin
                        nxt.phase       = PH_ACKED;
                        nxt.screen_mode = DISP_ACKED;
                        changed         = 1'b1;
                    end else begin
                        aw  = 1'b1;
                        err = ERR_UNEXP_ACK;
                    end
                end
                CMD_STATUS: begin
                    if (bad) begin
                        err = ERR_BAD_STATUS;
                    end else if (item.status_time > item.current_time) begin
                        err = ERR_FUTURE_TIME;
                    end else begin
                        nxt.status_hold = item.status_word;
                        if ((shortinv && cur.phase == PH_INACTIVE) ||
                            (longinv && (cur.phase == PH_INACTIVE ||
                                         cur.phase == PH_RECEIVING))) begin
                            nxt.screen_mode = DISP_SHORT_INVALID;
                            changed         = 1'b1;
                        end else if (cur.phase == PH_INACTIVE) begin
                            nxt.screen_mode = DISP_ALL_VALID;
                            changed         = 1'b1;
                        end else if (allfive && cur.phase != PH_RECEIVING) begin
                            nxt.phase       = PH_INACTIVE;
                            aw              = 1'b1;
                            awv             = 1'b1;
                            nxt.screen_mode = DISP_ALL_VALID;
                            changed         = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res.warning_phase   = phase_code(nxt.phase);
        res.expected_seq    = nxt.next_seq;
        res.seq_request     = seq_req;
        res.char_kind       = kind;
        res.char_value      = cval;
        res.display_state   = nxt.screen_mode;
        res.display_changed = changed;
        res.drop_client     = drop;
        res.ack_write       = aw;
        res.ack_write_value = awv;
        res.error_code      = err;
        res.last_status     = nxt.status_hold;
    end

endmodule

### rtl/core/warning_transfer_session_fsm.sv
// Top level of the warning transfer session engine: input register, event step, result register.
// Depends on wts_pkg and wts_event.

// One event word in, one result word out, one word per cycle sustained while
// m_tready is high. A word passes an input register, then the event logic
// updates the session registers and loads the result register, which then
// offers the word's result on m_tdata. The only loop is the session state
// feeding the event logic. Both registers hold under backpressure. The
// paired id on cfg_data takes effect for events taken after the write.
module warning_transfer_session_fsm import wts_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,     // stored_device_id
    input  logic         s_tvalid,
    output logic         s_tready,
    // device_id, message_length, chunk_seq, chunk_char, client_ack,
    // status_word, status_time, current_time, 7 bits zero pad
    input  logic [159:0] s_tdata,
    input  logic [2:0]   s_tuser,      // command
    output logic         m_tvalid,
    input  logic         m_tready,
    // warning_phase, expected_seq, seq_request, char_value, display_state,
    // display_changed, drop_client, ack_write, ack_write_value, error_code,
    // last_status, 3 bits zero pad
    output logic [55:0]  m_tdata,
    output logic [1:0]   m_tuser       // char_kind
);

    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    sess_t       sess_reg, sess_next;
    result_t     res_next;
    logic [31:0] id_reg;
    logic        adv;
    item_t       s_item;

    assign cfg_ready = 1'b1;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_comb begin
        s_item.command        = s_tuser;
        s_item.device_id      = s_tdata[31:0];
        s_item.message_length = s_tdata[47:32];
        s_item.chunk_seq      = s_tdata[63:48];
        s_item.chunk_char     = s_tdata[71:64];
        s_item.client_ack     = s_tdata[72];
        s_item.status_word    = s_tdata[88:73];
        s_item.status_time    = s_tdata[120:89];
        s_item.current_time   = s_tdata[152:121];
    end

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !m_tready);

    wts_event u_event (
        .item      (in_item_reg),
        .cur       (sess_reg),
        .stored_id (id_reg),
        .nxt       (sess_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            id_reg        <= '0;
            sess_reg      <= '{authenticated: 1'b0, phase: PH_INACTIVE, next_seq: '0,
                               total_chunks: '0, status_hold: '0,
                               screen_mode: DISP_WAIT_KNOWN};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) id_reg <= cfg_data;
            if (adv) sess_reg <= sess_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_item_reg <= s_item;
        if (adv) out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.char_kind;
    assign m_tdata  = {3'b000,
                       out_res_reg.last_status,
                       out_res_reg.error_code,
                       out_res_reg.ack_write_value,
                       out_res_reg.ack_write,
                       out_res_reg.drop_client,
                       out_res_reg.display_changed,
                       out_res_reg.display_state,
                       out_res_reg.char_value,
                       out_res_reg.seq_request,
                       out_res_reg.expected_seq,
                       out_res_reg.warning_phase};

`ifndef ASSERT_OFF
    a_drop_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.drop_client |->
            (out_res_reg.error_code == ERR_UNAUTH || out_res_reg.error_code == ERR_WRONG_ID))
        else $error("drop without matching error code");
    a_char_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.char_kind != KIND_NONE |->
            out_res_reg.seq_request && out_res_reg.error_code == ERR_OK)
        else $error("character accepted with error or no sequence request");
    a_ackval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.ack_write_value |-> out_res_reg.ack_write)
        else $error("ack value without ack write");
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(sess_reg.phase))
        else $error("phase register not one-hot");
    a_sess_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(sess_reg))
        else $error("session state changed without an event");
`endif

endmodule
